// ===== rtl/prax_pkg.sv =====
// prax_pkg: types, codes and helpers shared by the panel realign/axpy block.
// No dependencies; used by prax_fmul, prax_fadd and panel_realign_axpy.
package prax_pkg;

    localparam int PANEL_ROWS = 4;
    localparam int COL_WORDS  = 2 * PANEL_ROWS - 1;

    localparam logic [31:0] QNAN_BITS     = 32'h7FC0_0000;
    localparam logic [31:0] NEG_ZERO_BITS = 32'h8000_0000;
    localparam logic [31:0] ONE_BITS      = 32'h3F80_0000;

    // configuration register indexes
    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_ALPHA      = 2'd1;
    localparam logic [1:0] REG_ROW_OFFSET = 2'd2;
    localparam logic [1:0] REG_ROWS_USED  = 2'd3;

    // mode codes
    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_SCALE = 2'd1;
    localparam logic [1:0] MODE_ADD   = 2'd2;

    typedef enum logic [1:0] {
        SEL_DEST = 2'd0,
        SEL_A    = 2'd1,
        SEL_FPU  = 2'd2
    } t_lane_sel;

    typedef struct packed {
        logic [31:0] upper_0;
        logic [31:0] upper_1;
        logic [31:0] upper_2;
        logic [31:0] upper_3;
        logic [31:0] lower_0;
        logic [31:0] lower_1;
        logic [31:0] lower_2;
        logic [31:0] dest_0;
        logic [31:0] dest_1;
        logic [31:0] dest_2;
        logic [31:0] dest_3;
        logic        column_last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_0;
        logic [31:0] result_1;
        logic [31:0] result_2;
        logic [31:0] result_3;
        logic        result_last;
    } t_out_item;

    // sideband that travels with each column through the float pipeline
    typedef struct packed {
        logic                             last;
        logic                             scale;
        t_lane_sel [PANEL_ROWS-1:0]       sel;
        logic [PANEL_ROWS-1:0][31:0]      a;
        logic [PANEL_ROWS-1:0][31:0]      dest;
    } t_side;

    // leading zero count, MSB first; value of no meaning for zero input
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

endpackage

// ===== rtl/prax_fmul.sv =====
// prax_fmul: four-stage IEEE-754 single multiplier, round to nearest even,
// subnormals kept, NaN results canonical. Depends on prax_pkg.
module prax_fmul import prax_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);

    // stage 1: unpack and multiply
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

    logic [47:0]       r1_prod;
    logic signed [9:0] r1_exp;
    logic              r1_sign, r1_nan, r1_inf;

    always_comb begin
        ea     = i_a[30:23];
        eb     = i_b[30:23];
        ma     = {ea != 8'd0, i_a[22:0]};
        mb     = {eb != 8'd0, i_b[22:0]};
        nan_a  = (ea == 8'hFF) && (i_a[22:0] != 23'd0);
        nan_b  = (eb == 8'hFF) && (i_b[22:0] != 23'd0);
        inf_a  = (ea == 8'hFF) && (i_a[22:0] == 23'd0);
        inf_b  = (eb == 8'hFF) && (i_b[22:0] == 23'd0);
        zero_a = (i_a[30:0] == 31'd0);
        zero_b = (i_b[30:0] == 31'd0);
    end

    always_ff @(posedge i_clk) begin
        r1_prod <= ma * mb;
        r1_exp  <= $signed({2'b00, (ea == 8'd0) ? 8'd1 : ea})
                 + $signed({2'b00, (eb == 8'd0) ? 8'd1 : eb}) - 10'sd126;
        r1_sign <= i_a[31] ^ i_b[31];
        r1_nan  <= nan_a | nan_b | (inf_a & zero_b) | (inf_b & zero_a);
        r1_inf  <= inf_a | inf_b;
    end

    // stage 2: normalize left
    logic [5:0]        lz;
    logic [47:0]       r2_mant;
    logic signed [9:0] r2_exp;
    logic              r2_sign, r2_nan, r2_inf, r2_zero;

    assign lz = lzc48(r1_prod);

    always_ff @(posedge i_clk) begin
        r2_mant <= r1_prod << lz;
        r2_exp  <= r1_exp - $signed({4'b0000, lz});
        r2_sign <= r1_sign;
        r2_nan  <= r1_nan;
        r2_inf  <= r1_inf;
        r2_zero <= (r1_prod == 48'd0);
    end

    // stage 3: denormalize on underflow, form guard and sticky
    logic [5:0]        sh;
    logic signed [9:0] sh_full;
    logic [95:0]       wide;
    logic [23:0]       r3_m;
    logic [7:0]        r3_ef;
    logic              r3_g, r3_s, r3_ovf, r3_sign, r3_nan, r3_inf, r3_zero;

    always_comb begin
        sh_full = 10'sd1 - r2_exp;
        if (r2_exp > 10'sd0)       sh = 6'd0;
        else if (r2_exp < -10'sd61) sh = 6'd63;
        else                       sh = sh_full[5:0];
        wide = {r2_mant, 48'd0} >> sh;
    end

    always_ff @(posedge i_clk) begin
        r3_m    <= wide[95:72];
        r3_g    <= wide[71];
        r3_s    <= |wide[70:0];
        r3_ef   <= (r2_exp > 10'sd0) ? r2_exp[7:0] : 8'd0;
        r3_ovf  <= (r2_exp > 10'sd254);
        r3_sign <= r2_sign;
        r3_nan  <= r2_nan;
        r3_inf  <= r2_inf;
        r3_zero <= r2_zero;
    end

    // stage 4: round and pack
    logic [30:0] packed_mag;
    logic        inc;

    always_comb begin
        inc        = r3_g & (r3_s | r3_m[0]);
        packed_mag = {r3_ef, r3_m[22:0]} + {30'd0, inc};
    end

    always_ff @(posedge i_clk) begin
        if (r3_nan)                o_p <= QNAN_BITS;
        else if (r3_inf || r3_ovf) o_p <= {r3_sign, 8'hFF, 23'd0};
        else if (r3_zero)          o_p <= {r3_sign, 31'd0};
        else                       o_p <= {r3_sign, packed_mag};
    end

endmodule

// ===== rtl/prax_fadd.sv =====
// prax_fadd: four-stage IEEE-754 single adder, round to nearest even,
// subnormals kept, NaN results canonical. Depends on prax_pkg.
module prax_fadd import prax_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic [31:0] o_s
);

    // stage 1: order by magnitude, flag specials
    logic        swap;
    logic [31:0] big, sml;
    logic [7:0]  eb_eff, es_eff;
    logic        nan_x, nan_y, inf_x, inf_y;

    logic [23:0] r1_mb, r1_ms;
    logic [7:0]  r1_eb, r1_d;
    logic        r1_sign, r1_sub, r1_nan, r1_inf, r1_isign, r1_zsign;

    always_comb begin
        swap   = i_y[30:0] > i_x[30:0];
        big    = swap ? i_y : i_x;
        sml    = swap ? i_x : i_y;
        eb_eff = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es_eff = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        nan_x  = (i_x[30:23] == 8'hFF) && (i_x[22:0] != 23'd0);
        nan_y  = (i_y[30:23] == 8'hFF) && (i_y[22:0] != 23'd0);
        inf_x  = (i_x[30:23] == 8'hFF) && (i_x[22:0] == 23'd0);
        inf_y  = (i_y[30:23] == 8'hFF) && (i_y[22:0] == 23'd0);
    end

    always_ff @(posedge i_clk) begin
        r1_mb    <= {big[30:23] != 8'd0, big[22:0]};
        r1_ms    <= {sml[30:23] != 8'd0, sml[22:0]};
        r1_eb    <= eb_eff;
        r1_d     <= eb_eff - es_eff;
        r1_sign  <= big[31];
        r1_sub   <= i_x[31] ^ i_y[31];
        r1_nan   <= nan_x | nan_y | (inf_x & inf_y & (i_x[31] ^ i_y[31]));
        r1_inf   <= inf_x | inf_y;
        r1_isign <= inf_x ? i_x[31] : i_y[31];
        r1_zsign <= i_x[31] & i_y[31];
    end

    // stage 2: align smaller operand, add or subtract
    logic [4:0]  dc;
    logic [57:0] al_wide;
    logic [26:0] al;

    logic [27:0] r2_sum;
    logic [7:0]  r2_exp;
    logic        r2_sign, r2_nan, r2_inf, r2_isign, r2_zsign;

    always_comb begin
        dc      = (r1_d > 8'd31) ? 5'd31 : r1_d[4:0];
        al_wide = {r1_ms, 34'd0} >> dc;
        al      = {al_wide[57:32], al_wide[31] | (|al_wide[30:0])};
    end

    always_ff @(posedge i_clk) begin
        r2_sum   <= r1_sub ? ({1'b0, r1_mb, 3'd0} - {1'b0, al})
                           : ({1'b0, r1_mb, 3'd0} + {1'b0, al});
        r2_exp   <= r1_eb;
        r2_sign  <= r1_sign;
        r2_nan   <= r1_nan;
        r2_inf   <= r1_inf;
        r2_isign <= r1_isign;
        r2_zsign <= r1_zsign;
    end

    // stage 3: normalize, stop at the subnormal boundary
    logic [5:0]  lz, shamt;
    logic [26:0] n;
    logic [8:0]  e;

    logic [23:0] r3_m;
    logic [7:0]  r3_ef;
    logic        r3_g, r3_s, r3_ovf, r3_zero;
    logic        r3_sign, r3_nan, r3_inf, r3_isign, r3_zsign;

    always_comb begin
        lz = lzc48({r2_sum[26:0], 21'd0});
        if (r2_sum[27]) begin
            n     = {r2_sum[27:2], r2_sum[1] | r2_sum[0]};
            e     = {1'b0, r2_exp} + 9'd1;
            shamt = 6'd0;
        end else begin
            shamt = ({3'd0, lz} < {1'b0, r2_exp} - 9'd1) ? lz
                                                          : 6'(r2_exp - 8'd1);
            n     = r2_sum[26:0] << shamt;
            e     = {1'b0, r2_exp} - {3'd0, shamt};
        end
    end

    always_ff @(posedge i_clk) begin
        r3_m     <= n[26:3];
        r3_g     <= n[2];
        r3_s     <= |n[1:0];
        r3_ef    <= n[26] ? e[7:0] : 8'd0;
        r3_ovf   <= (e > 9'd254);
        r3_zero  <= (r2_sum == 28'd0);
        r3_sign  <= r2_sign;
        r3_nan   <= r2_nan;
        r3_inf   <= r2_inf;
        r3_isign <= r2_isign;
        r3_zsign <= r2_zsign;
    end

    // stage 4: round and pack
    logic [30:0] packed_mag;
    logic        inc;

    always_comb begin
        inc        = r3_g & (r3_s | r3_m[0]);
        packed_mag = {r3_ef, r3_m[22:0]} + {30'd0, inc};
    end

    always_ff @(posedge i_clk) begin
        if (r3_nan)       o_s <= QNAN_BITS;
        else if (r3_inf)  o_s <= {r3_isign, 8'hFF, 23'd0};
        else if (r3_ovf)  o_s <= {r3_sign, 8'hFF, 23'd0};
        else if (r3_zero) o_s <= {r3_zsign, 31'd0};
        else              o_s <= {r3_sign, packed_mag};
    end

endmodule

// ===== rtl/panel_realign_axpy.sv =====
// panel_realign_axpy: realigning copy / scale / accumulate over one
// panel-major column per transaction. Depends on prax_pkg, prax_fmul, prax_fadd.

// One column is taken in every clock cycle; o_busy never rises. Each column's
// result appears on o_result with o_valid high for one cycle, after passing
// the input register, the four-stage multiplier, the four-stage adder and the
// output register; that path is the same in every mode. The receiver cannot
// stall the block. Configuration is sampled when a column enters, so write it
// only between runs.
module panel_realign_axpy import prax_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_in_item    i_in,
    output logic        o_valid,
    output t_out_item   o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    localparam int DEPTH = 9;   // input stage + multiplier + adder

    logic [1:0]  r_mode;
    logic [31:0] r_alpha;
    logic [1:0]  r_row_offset;
    logic [2:0]  r_rows_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_COPY;
            r_alpha      <= ONE_BITS;
            r_row_offset <= 2'd0;
            r_rows_used  <= 3'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:       r_mode       <= i_cfg_wdata[1:0];
                REG_ALPHA:      r_alpha      <= i_cfg_wdata;
                REG_ROW_OFFSET: r_row_offset <= i_cfg_wdata[1:0];
                REG_ROWS_USED:  r_rows_used  <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // column select and lane decode
    logic [COL_WORDS-1:0][31:0]  col;
    logic [PANEL_ROWS-1:0][31:0] dest_in;
    t_side                       n_side;

    always_comb begin
        col     = {i_in.lower_2, i_in.lower_1, i_in.lower_0,
                   i_in.upper_3, i_in.upper_2, i_in.upper_1, i_in.upper_0};
        dest_in = {i_in.dest_3, i_in.dest_2, i_in.dest_1, i_in.dest_0};
        n_side.last  = i_in.column_last;
        n_side.scale = (r_mode == MODE_SCALE);
        n_side.dest  = dest_in;
        for (int i = 0; i < PANEL_ROWS; i++) begin
            n_side.a[i] = col[3'(r_row_offset) + 3'(i)];
            if (3'(i) < r_rows_used) begin
                case (r_mode) inside
                    MODE_COPY:             n_side.sel[i] = SEL_A;
                    MODE_SCALE, MODE_ADD:  n_side.sel[i] = SEL_FPU;
                    default:               n_side.sel[i] = SEL_DEST;
                endcase
            end else begin
                n_side.sel[i] = SEL_DEST;
            end
        end
    end

    t_side             r_side [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [31:0]       r_alpha_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[DEPTH-2:0], i_start & ~o_busy};
    end

    always_ff @(posedge i_clk) begin
        r_side[0]  <= n_side;
        r_alpha_s0 <= r_alpha;
        for (int k = 1; k < DEPTH; k++) r_side[k] <= r_side[k-1];
    end

    logic [PANEL_ROWS-1:0][31:0] prod, addend, fsum;

    for (genvar g = 0; g < PANEL_ROWS; g++) begin : g_lane
        prax_fmul u_mul (
            .i_clk (i_clk),
            .i_a   (r_alpha_s0),
            .i_b   (r_side[0].a[g]),
            .o_p   (prod[g])
        );

        // scale mode adds -0, which leaves every product exactly as it is
        assign addend[g] = r_side[4].scale ? NEG_ZERO_BITS : r_side[4].dest[g];

        prax_fadd u_add (
            .i_clk (i_clk),
            .i_x   (addend[g]),
            .i_y   (prod[g]),
            .o_s   (fsum[g])
        );
    end

    logic [PANEL_ROWS-1:0][31:0] lane_out;

    always_comb begin
        for (int i = 0; i < PANEL_ROWS; i++) begin
            case (r_side[DEPTH-1].sel[i])
                SEL_A:   lane_out[i] = r_side[DEPTH-1].a[i];
                SEL_FPU: lane_out[i] = fsum[i];
                default: lane_out[i] = r_side[DEPTH-1].dest[i];
            endcase
        end
    end

    logic      r_out_vld;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else          r_out_vld <= r_vld[DEPTH-1];
    end

    always_ff @(posedge i_clk) begin
        r_out.result_0    <= lane_out[0];
        r_out.result_1    <= lane_out[1];
        r_out.result_2    <= lane_out[2];
        r_out.result_3    <= lane_out[3];
        r_out.result_last <= r_side[DEPTH-1].last;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule
